/* rtl/lsca_pkg.sv */
`timescale 1ns / 1ps

package lsca_pkg;

   // Widths fixed by the word formats on the ports.
   localparam int CLIENT_W = 4;
   localparam int DEBT_OUT_W = 16;
   localparam logic [31:0] DEBT_OUT_MAX = 32'h0000_FFFF;

   // Defaults for the top-level parameters.
   localparam int NUM_CLIENTS_DEF = 16;
   localparam int DEBT_BITS_DEF = 16;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Action codes carried in a request word.
   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_RELEASE,
      OP_IGNORE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILE,
      ST_SCAN,
      ST_PICK,
      ST_GRANT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                action;
      logic [CLIENT_W-1:0] client;
   } req_word_type;

   typedef struct packed {
      logic                  granted;
      logic [CLIENT_W-1:0]   grant_client;
      logic [DEBT_OUT_W-1:0] client_debt;
      logic                  busy_res;
   } rsp_word_type;

   // A classified command as it travels through the queue.
   typedef struct packed {
      op_type              op;
      logic [CLIENT_W-1:0] client;
   } cmd_type;

endpackage

/* rtl/lsca_ram.sv */
`timescale 1ns / 1ps

module lsca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lsca_front.sv */
`timescale 1ns / 1ps

module lsca_front #(
   parameter int NUM_CLIENTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lsca_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output lsca_pkg::cmd_type     cmd
);

   import lsca_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   cmd_type           cmd_new;
   logic              push;
   logic              pop;

   // Clients past the configured count are turned into no-op commands here.
   always_comb begin
      cmd_new.client = req_word.client;
      if (32'(req_word.client) >= 32'(NUM_CLIENTS)) begin
         cmd_new.op = OP_IGNORE;
      end else begin
         case (req_word.action)
            ACT_REQUEST: cmd_new.op = OP_REQUEST;
            ACT_RELEASE: cmd_new.op = OP_RELEASE;
            default:     cmd_new.op = OP_IGNORE;
         endcase
      end
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

/* rtl/lsca_back.sv */
`timescale 1ns / 1ps

module lsca_back #(
   parameter int NUM_CLIENTS = 16,
   parameter int DEBT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  lsca_pkg::cmd_type      cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lsca_pkg::rsp_word_type rsp_word
);

   import lsca_pkg::*;

   localparam int CIDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int CNT_W = $clog2(NUM_CLIENTS + 1);
   localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(NUM_CLIENTS - 1);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff;
   logic [DEBT_BITS-1:0]  svc_ff [NUM_CLIENTS];
   logic [NUM_CLIENTS-1:0] wait_ff;
   logic [CIDX_W-1:0]     rank_ff [NUM_CLIENTS];
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  held_ff, held_in;

   logic [CIDX_W-1:0]     scan_addr_ff;
   logic [CIDX_W-1:0]     idx_d_ff;
   logic                  d_valid_ff;
   logic                  found_ff;
   logic [CIDX_W-1:0]     best_idx_ff;
   logic [DEBT_BITS-1:0]  best_debt_ff;
   logic [CIDX_W-1:0]     best_rank_ff;
   logic                  granted_ff;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  pop;
   logic                  do_file;
   logic                  scan_issue;
   logic                  do_grant;
   logic                  load_rsp;

   logic                  is_req;
   logic [CIDX_W-1:0]     c_idx;
   logic [CIDX_W-1:0]     rank_addr;
   logic                  wait_sel;
   logic [CIDX_W-1:0]     rank_sel;
   logic                  leave_en;
   logic [CIDX_W-1:0]     leave_idx;
   logic [CIDX_W-1:0]     leave_rank;
   logic [CNT_W-1:0]      total_left;
   logic                  file_req;
   logic [DEBT_BITS-1:0]  rd_debt;
   logic                  better;
   logic [31:0]           debt_wide;

   assign is_req   = (cmd_ff.op == OP_REQUEST);
   assign c_idx    = CIDX_W'(cmd_ff.client);
   assign file_req = do_file && is_req;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.op == OP_IGNORE) ? ST_DONE : ST_FILE;
            end
         end
         ST_FILE: begin
            if (is_req ? !held_ff : (total_ff != '0)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST_IDX) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK:  state_in = ST_GRANT;
         ST_GRANT: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control strobes.
   always_comb begin
      pop        = 1'b0;
      do_file    = 1'b0;
      scan_issue = 1'b0;
      do_grant   = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:  pop        = cmd_valid;
         ST_FILE:  do_file    = 1'b1;
         ST_SCAN:  scan_issue = 1'b1;
         ST_GRANT: do_grant   = found_ff;
         ST_DONE:  load_rsp   = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign cmd_ready = pop;

   // One read port on the rank and waiting arrays: the filing client while
   // filing, otherwise the entry whose ticket is arriving from the RAM.
   assign rank_addr = (state_ff == ST_FILE) ? c_idx : idx_d_ff;
   assign wait_sel  = wait_ff[rank_addr];
   assign rank_sel  = rank_ff[rank_addr];

   // A client leaves the line either when it files a fresh ticket or when
   // it is granted; everyone behind it moves up by one.
   assign leave_en   = (file_req && wait_sel) || do_grant;
   assign leave_idx  = do_grant ? best_idx_ff : c_idx;
   assign leave_rank = do_grant ? best_rank_ff : rank_sel;
   assign total_left = total_ff - CNT_W'(leave_en);

   always_comb begin
      total_in = total_ff;
      held_in  = held_ff;
      if (file_req) begin
         total_in = total_left + 1'b1;
      end else if (do_grant) begin
         total_in = total_left;
      end
      if (do_file && !is_req) begin
         held_in = 1'b0;
      end else if (do_grant) begin
         held_in = 1'b1;
      end
   end

   lsca_ram #(
      .WIDTH (DEBT_BITS),
      .DEPTH (NUM_CLIENTS)
   ) u_ticket_ram (
      .clock   (clock),
      .wr_en   (file_req),
      .wr_addr (c_idx),
      .wr_data (svc_ff[c_idx]),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_debt)
   );

   // Lower debt wins, and the earlier arrival wins a tie.
   assign better = d_valid_ff && wait_sel &&
                   (!found_ff || (rd_debt < best_debt_ff) ||
                    ((rd_debt == best_debt_ff) && (rank_sel < best_rank_ff)));

   assign debt_wide = 32'(svc_ff[c_idx]);

   always_comb begin
      rsp_word_in.granted      = granted_ff;
      rsp_word_in.grant_client = granted_ff ? CLIENT_W'(best_idx_ff) : '0;
      rsp_word_in.busy_res     = held_ff;
      if (cmd_ff.op == OP_IGNORE) begin
         rsp_word_in.client_debt = '0;
      end else if (debt_wide > DEBT_OUT_MAX) begin
         rsp_word_in.client_debt = '1;
      end else begin
         rsp_word_in.client_debt = debt_wide[DEBT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         held_ff      <= 1'b0;
         wait_ff      <= '0;
         d_valid_ff   <= 1'b0;
         found_ff     <= 1'b0;
         granted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLIENTS; i++) begin
            svc_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         held_ff    <= held_in;
         d_valid_ff <= scan_issue;
         if (leave_en) begin
            wait_ff[leave_idx] <= 1'b0;
         end
         if (file_req) begin
            wait_ff[c_idx] <= 1'b1;
         end
         if (do_file && !is_req && (svc_ff[c_idx] != '1)) begin
            svc_ff[c_idx] <= svc_ff[c_idx] + 1'b1;
         end
         if (do_file) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
         if (pop) begin
            granted_ff <= 1'b0;
         end else if (do_grant) begin
            granted_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
         if (leave_en && wait_ff[i] && (rank_ff[i] > leave_rank)) begin
            rank_ff[i] <= rank_ff[i] - 1'b1;
         end
      end
      if (file_req) begin
         rank_ff[c_idx] <= CIDX_W'(total_left);
      end
      if (pop) begin
         cmd_ff <= cmd;
      end
      if (do_file) begin
         scan_addr_ff <= '0;
      end else if (scan_issue) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      if (scan_issue) begin
         idx_d_ff <= scan_addr_ff;
      end
      if (better) begin
         best_idx_ff  <= idx_d_ff;
         best_debt_ff <= rd_debt;
         best_rank_ff <= rank_sel;
      end
      if (load_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/least_served_client_arbiter_top.sv */
`timescale 1ns / 1ps

// Least-served client arbiter. Each request word carries a request or a
// release from one client; each accepted word yields exactly one response
// word, in order. A request files a ticket holding the client's current
// service count (its debt) and moves it to the back of the line, replacing
// any ticket it already had. A release adds one to the client's debt,
// saturating, and frees the resource. Whenever the resource is free, the
// waiter with the lowest ticket debt is granted, ties going to the earlier
// arrival, and the response reports that grant. Words for clients at or
// above NUM_CLIENTS change nothing and return zero debt. A two-entry queue
// takes request words while the back end works, so the input stalls only
// when that queue is full. The back end handles one word at a time: a word
// that triggers a search for the next holder passes through a scan that
// reads one ticket per cycle from the single read port of the ticket RAM;
// a request while the resource is held, or a release with nobody waiting,
// skips the scan, and an out-of-range word also skips the filing step.
// Ticket storage needs no clearing after reset, so the block is ready as
// soon as reset is released.
module least_served_client_arbiter_top #(
   parameter int NUM_CLIENTS = lsca_pkg::NUM_CLIENTS_DEF,
   parameter int DEBT_BITS = lsca_pkg::DEBT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lsca_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lsca_pkg::rsp_word_type rsp_word
);

   import lsca_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // The front end classifies each word and queues it.
   lsca_front #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // The back end updates the line, searches for the next holder and
   // registers the response word.
   lsca_back #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .DEBT_BITS   (DEBT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // The back end never takes a command the queue does not hold.
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> cmd_valid)
      else $error("back end popped an empty command queue");

   // A grant always leaves the resource held.
   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.granted) |-> rsp_word.busy_res)
      else $error("grant reported with resource free");

   // Without a grant, the granted client index reads as zero.
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.granted) |-> (rsp_word.grant_client == '0))
      else $error("grant client index set without a grant");

endmodule
